### sv/integer_to_ascii_radix_core_defines.svh
// assertion macros shared by the conversion core modules
`ifndef INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ITAR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("itar: implication check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define ITAR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("itar: next-cycle check failed");

`endif

### sv/itar_pkg.sv
// shared constants, types and character table for the conversion core
package itar_pkg;

    localparam logic [1:0] SIZE_16   = 2'd0;
    localparam logic [1:0] SIZE_32   = 2'd1;
    localparam logic [1:0] SIZE_64   = 2'd2;
    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;

    localparam int DIG_W     = 4;
    localparam int MAX_DIGS  = 22;
    localparam int DIGVEC_W  = DIG_W * MAX_DIGS;
    localparam int BCD_DIGS  = 20;
    localparam int BCD_W     = DIG_W * BCD_DIGS;

    localparam logic [6:0] ASCII_MINUS = 7'h2d;

    localparam logic [6:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic align;
        logic shift;
        logic out_sign;
        logic out_digit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic conv_done;
        logic negative;
        logic top_zero;
        logic rem_one;
        logic out_free;
    } t_stat;

endpackage

### sv/itar_intf.sv
// request and result channel interfaces of the conversion core
interface itar_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] operand_value;
    logic [1:0]  operand_size;
    logic        signed_mode;
    logic [1:0]  radix_select;

    modport source (output valid, output operand_value, output operand_size,
                    output signed_mode, output radix_select, input ready);
    modport sink   (input valid, input operand_value, input operand_size,
                    input signed_mode, input radix_select, output ready);
endinterface

interface itar_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;
    logic       last_char;

    modport source (output valid, output ascii_char, output last_char, input ready);
    modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

### sv/itar_dp.sv
// datapath: magnitude, bcd conversion, digit vector and result register
`include "integer_to_ascii_radix_core_defines.svh"

module itar_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [63:0]      i_operand_value,
    input  logic [1:0]       i_operand_size,
    input  logic             i_signed_mode,
    input  logic [1:0]       i_radix_select,
    input  itar_pkg::t_cmd   i_cmd,
    output itar_pkg::t_stat  o_stat,
    input  logic             i_rsp_ready,
    output logic             o_rsp_valid,
    output logic [6:0]       o_ascii_char,
    output logic             o_last_char
);

    // four double-dabble bit steps, one nibble of the operand
    function automatic logic [itar_pkg::BCD_W-1:0] dabble4(
        input logic [itar_pkg::BCD_W-1:0] bcd,
        input logic [3:0]                 nib
    );
        logic [itar_pkg::BCD_W-1:0] b;
        b = bcd;
        for (int k = 3; k >= 0; k--) begin
            for (int d = 0; d < itar_pkg::BCD_DIGS; d++) begin
                if (b[4*d +: 4] >= 4'd5) begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            b = {b[itar_pkg::BCD_W-2:0], nib[k]};
        end
        return b;
    endfunction

    logic [63:0]                   r_mag;
    logic                          r_neg;
    logic [1:0]                    r_size;
    logic [1:0]                    r_rad;
    logic [4:0]                    r_steps;
    logic [4:0]                    r_rem;
    logic [itar_pkg::DIGVEC_W-1:0] r_dig;
    logic                          r_o_valid;
    logic [6:0]                    r_o_char;
    logic                          r_o_last;

    logic [63:0]                   w_mask;
    logic [63:0]                   w_sign;
    logic [63:0]                   w_masked;
    logic                          w_neg_in;
    logic [63:0]                   w_mag_in;
    logic [4:0]                    w_steps_in;
    logic [3:0]                    w_nib;
    logic [65:0]                   w_oct;
    logic [63:0]                   w_hex;
    logic [itar_pkg::DIGVEC_W-1:0] w_align_dig;
    logic [4:0]                    w_align_rem;
    logic [3:0]                    w_top;

    // operand sizing and magnitude
    always_comb begin
        case (i_operand_size)
            itar_pkg::SIZE_16: begin
                w_mask = 64'h0000_0000_0000_ffff;
                w_sign = 64'h0000_0000_0000_8000;
            end
            itar_pkg::SIZE_32: begin
                w_mask = 64'h0000_0000_ffff_ffff;
                w_sign = 64'h0000_0000_8000_0000;
            end
            default: begin
                w_mask = 64'hffff_ffff_ffff_ffff;
                w_sign = 64'h8000_0000_0000_0000;
            end
        endcase
        w_masked = i_operand_value & w_mask;
        w_neg_in = i_signed_mode && (|(w_masked & w_sign));
        w_mag_in = w_neg_in ? ((~w_masked + 64'd1) & w_mask) : w_masked;
        if (i_radix_select == itar_pkg::RADIX_DEC) begin
            case (i_operand_size)
                itar_pkg::SIZE_16: w_steps_in = 5'd4;
                itar_pkg::SIZE_32: w_steps_in = 5'd8;
                default:           w_steps_in = 5'd16;
            endcase
        end else begin
            w_steps_in = 5'd0;
        end
    end

    // top nibble of the sized operand feeds the bcd converter
    always_comb begin
        case (r_size)
            itar_pkg::SIZE_16: w_nib = r_mag[15:12];
            itar_pkg::SIZE_32: w_nib = r_mag[31:28];
            default:           w_nib = r_mag[63:60];
        endcase
    end

    // left-align the digits so the leading one sits in the top slot
    always_comb begin
        case (r_size)
            itar_pkg::SIZE_16: begin
                w_oct = {2'b00, r_mag[15:0], 48'd0};
                w_hex = {r_mag[15:0], 48'd0};
            end
            itar_pkg::SIZE_32: begin
                w_oct = {1'b0, r_mag[31:0], 33'd0};
                w_hex = {r_mag[31:0], 32'd0};
            end
            default: begin
                w_oct = {2'b00, r_mag};
                w_hex = r_mag;
            end
        endcase
        w_align_dig = '0;
        if (r_rad == itar_pkg::RADIX_OCT) begin
            for (int j = 0; j < itar_pkg::MAX_DIGS; j++) begin
                w_align_dig[itar_pkg::DIGVEC_W-1-4*j -: 4] = {1'b0, w_oct[65-3*j -: 3]};
            end
            case (r_size)
                itar_pkg::SIZE_16: w_align_rem = 5'd6;
                itar_pkg::SIZE_32: w_align_rem = 5'd11;
                default:           w_align_rem = 5'd22;
            endcase
        end else if (r_rad == itar_pkg::RADIX_DEC) begin
            case (r_size)
                itar_pkg::SIZE_16: begin
                    w_align_dig = r_dig << 68;
                    w_align_rem = 5'd5;
                end
                itar_pkg::SIZE_32: begin
                    w_align_dig = r_dig << 48;
                    w_align_rem = 5'd10;
                end
                default: begin
                    w_align_dig = r_dig << 8;
                    w_align_rem = 5'd20;
                end
            endcase
        end else begin
            w_align_dig = {w_hex, 24'd0};
            case (r_size)
                itar_pkg::SIZE_16: w_align_rem = 5'd4;
                itar_pkg::SIZE_32: w_align_rem = 5'd8;
                default:           w_align_rem = 5'd16;
            endcase
        end
    end

    assign w_top = r_dig[itar_pkg::DIGVEC_W-1 -: 4];

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag   <= w_mag_in;
            r_neg   <= w_neg_in;
            r_size  <= (i_operand_size == itar_pkg::SIZE_16 ||
                        i_operand_size == itar_pkg::SIZE_32) ? i_operand_size
                                                              : itar_pkg::SIZE_64;
            r_rad   <= i_radix_select;
            r_steps <= w_steps_in;
            r_dig   <= '0;
        end else if (i_cmd.step) begin
            r_mag   <= {r_mag[59:0], 4'd0};
            r_steps <= r_steps - 5'd1;
            r_dig   <= {8'd0, dabble4(r_dig[itar_pkg::BCD_W-1:0], w_nib)};
        end else if (i_cmd.align) begin
            r_dig   <= w_align_dig;
            r_rem   <= w_align_rem;
        end else if (i_cmd.shift) begin
            r_dig   <= {r_dig[itar_pkg::DIGVEC_W-5:0], 4'd0};
            r_rem   <= r_rem - 5'd1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_sign || i_cmd.out_digit) begin
            r_o_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_sign) begin
            r_o_char <= itar_pkg::ASCII_MINUS;
            r_o_last <= 1'b0;
        end else if (i_cmd.out_digit) begin
            r_o_char <= itar_pkg::DIGIT_CHARS[w_top];
            r_o_last <= (r_rem == 5'd1);
        end
    end

    assign o_stat.conv_done = (r_steps == 5'd0);
    assign o_stat.negative  = r_neg;
    assign o_stat.top_zero  = (w_top == 4'd0);
    assign o_stat.rem_one   = (r_rem == 5'd1);
    assign o_stat.out_free  = !r_o_valid || i_rsp_ready;

    assign o_rsp_valid  = r_o_valid;
    assign o_ascii_char = r_o_char;
    assign o_last_char  = r_o_last;

    `ITAR_ASSERT_IMP(a_shift_has_digit, i_cmd.shift, (r_rem != 5'd0))
    `ITAR_ASSERT_NEXT(a_digit_shown, i_cmd.out_digit, (r_o_valid && (r_o_last == $past(r_rem == 5'd1))))

endmodule

### sv/itar_ctrl.sv
// controller: sequences load, conversion, zero skip and character output
`include "integer_to_ascii_radix_core_defines.svh"

module itar_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  itar_pkg::t_stat  i_stat,
    output itar_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_SKIP  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // nothing is taken while reset is held
                o_req_ready = i_rst_n;
                if (i_req_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                if (i_stat.conv_done) begin
                    o_cmd.align = 1'b1;
                    n_state     = ST_SKIP;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_SKIP: begin
                if (i_stat.top_zero && !i_stat.rem_one) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    n_state = i_stat.negative ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_sign = 1'b1;
                    n_state        = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_digit = 1'b1;
                    o_cmd.shift     = 1'b1;
                    if (i_stat.rem_one) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ITAR_ASSERT_IMP(a_sign_when_negative, (r_state == ST_SIGN), i_stat.negative)
    `ITAR_ASSERT_NEXT(a_skip_ends_on_digit, (r_state == ST_SKIP && !i_stat.top_zero), (r_state != ST_SKIP))
    `ITAR_ASSERT_NEXT(a_last_returns_idle, (o_cmd.out_digit && i_stat.rem_one), (r_state == ST_IDLE))

endmodule

### sv/integer_to_ascii_radix_core.sv
// Integer to ASCII conversion core, radix 8, 10 or 16, one character per result request.
// An operand of 16, 32 or 64 bits (size code three counts as 64) is taken on the request
// channel and printed most significant digit first, lowercase hex, at least one digit;
// radix code three counts as hex. In signed mode a negative operand gets a leading '-'
// and its magnitude is formed exactly, the most negative value included. The final
// character of each number carries last_char. One operand is worked on at a time: the
// next request is taken once the last character has gone into the result register.
// For each radix and size the digit slots number octal 6/11/22, decimal 5/10/20 and
// hex 4/8/16; a minus sign adds one character. A decimal operand first passes through
// the double-dabble unit, which takes four operand bits a cycle; octal and hex skip
// it. Leading zero digits are dropped one a cycle, down to the last digit.
module integer_to_ascii_radix_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itar_req_if.sink   i_req,
    itar_rsp_if.source o_rsp
);

    // command and status between the sequencer and the datapath
    itar_pkg::t_cmd  w_cmd;
    itar_pkg::t_stat w_stat;

    logic       w_req_ready;
    logic       w_rsp_valid;
    logic [6:0] w_ascii_char;
    logic       w_last_char;

    // sequencer: accepts a request only when idle, then walks the phases
    itar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: magnitude, bcd converter, digit vector, result register
    itar_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_operand_value (i_req.operand_value),
        .i_operand_size  (i_req.operand_size),
        .i_signed_mode   (i_req.signed_mode),
        .i_radix_select  (i_req.radix_select),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (w_rsp_valid),
        .o_ascii_char    (w_ascii_char),
        .o_last_char     (w_last_char)
    );

    // channel hookup
    assign i_req.ready      = w_req_ready;
    assign o_rsp.valid      = w_rsp_valid;
    assign o_rsp.ascii_char = w_ascii_char;
    assign o_rsp.last_char  = w_last_char;

endmodule

### tb/sv/integer_to_ascii_radix_core_test.sv
// self-checking testbench for the integer to ascii conversion core
`timescale 1ns / 100ps

module integer_to_ascii_radix_core_test;

    // codes the package leaves unnamed
    localparam logic [1:0] SIZE_ALT  = 2'd3;  // code three, behaves as 64-bit
    localparam logic [1:0] RADIX_HEX = 2'd2;
    localparam logic [1:0] RADIX_ALT = 2'd3;  // code three, behaves as hex

    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_A    = 7'h61;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 450;
    localparam int HOLD_AFTER   = 900;   // characters seen before the long hold-off
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;    // idle time after the last owed character has arrived

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last_char;
    } t_char_result;

    // one stimulus row; an empty golden string means the predictor decides
    typedef struct {
        logic [63:0] value;
        logic [1:0]  size;
        logic        is_signed;
        logic [1:0]  radix;
        string       golden;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    itar_req_if req_bus ();
    itar_rsp_if rsp_bus ();

    integer_to_ascii_radix_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_char_result  pending_chars [$];   // characters still owed by the core
    int            error_count = 0;
    t_directed_row directed_rows [N_DIRECTED];

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // reset held low at the start, then released, once
    initial begin
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // queue the characters of one number, most significant first
    function automatic void predict_characters(input logic [63:0] raw,
                                               input logic [1:0]  size,
                                               input logic        is_signed,
                                               input logic [1:0]  radix);
        logic [63:0]  mask;
        logic [63:0]  sign_bit;
        logic [63:0]  base;
        logic [63:0]  mag;
        logic [63:0]  digit;
        logic [6:0]   digits [$];
        t_char_result entry;

        case (size)
            itar_pkg::SIZE_16: begin
                mask     = 64'h0000_0000_0000_ffff;
                sign_bit = 64'h0000_0000_0000_8000;
            end
            itar_pkg::SIZE_32: begin
                mask     = 64'h0000_0000_ffff_ffff;
                sign_bit = 64'h0000_0000_8000_0000;
            end
            default: begin
                mask     = 64'hffff_ffff_ffff_ffff;
                sign_bit = 64'h8000_0000_0000_0000;
            end
        endcase

        case (radix)
            itar_pkg::RADIX_OCT: base = 64'd8;
            itar_pkg::RADIX_DEC: base = 64'd10;
            default:             base = 64'd16;
        endcase

        mag = raw & mask;
        if (is_signed && (mag & sign_bit) != 64'd0) begin
            // magnitude within the operand size, exact for the most negative value
            mag = (~mag + 64'd1) & mask;
            entry.ascii_char = itar_pkg::ASCII_MINUS;
            entry.last_char  = 1'b0;
            pending_chars.push_back(entry);
        end

        // at least one digit, even for zero
        do begin
            digit = mag % base;
            mag   = mag / base;
            digits.push_front(digit < 64'd10 ? CHAR_ZERO + 7'(digit)
                                             : CHAR_A + 7'(digit - 64'd10));
        end while (mag != 64'd0);

        foreach (digits[i]) begin
            entry.ascii_char = digits[i];
            entry.last_char  = (i == digits.size() - 1);
            pending_chars.push_back(entry);
        end
    endfunction

    // queue the characters of a typed-in expected string
    function automatic void queue_golden(input string golden);
        t_char_result entry;
        byte          ch;
        for (int i = 0; i < golden.len(); i++) begin
            ch               = golden[i];
            entry.ascii_char = ch[6:0];
            entry.last_char  = (i == golden.len() - 1);
            pending_chars.push_back(entry);
        end
    endfunction

    // offer one request, idling first at random unless told to keep going
    task automatic offer_request(input logic [63:0] value, input logic [1:0] size,
                                 input logic is_signed, input logic [1:0] radix,
                                 input string golden, input bit no_idle);
        while (!no_idle && $urandom_range(0, 99) < 19) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.operand_value <= value;
        req_bus.operand_size  <= size;
        req_bus.signed_mode   <= is_signed;
        req_bus.radix_select  <= radix;
        do @(posedge i_clk); while (!req_bus.ready);
        // accepted at this edge
        if (golden.len() != 0)
            queue_golden(golden);
        else
            predict_characters(value, size, is_signed, radix);
    endtask

    // request side: directed table, then random operands, then drain
    initial begin
        logic [63:0] value;
        logic [1:0]  size;
        logic        is_signed;
        logic [1:0]  radix;
        int          op_width;
        int          shape;

        req_bus.valid         <= 1'b0;
        req_bus.operand_value <= '0;
        req_bus.operand_size  <= '0;
        req_bus.signed_mode   <= 1'b0;
        req_bus.radix_select  <= '0;

        directed_rows = '{
            '{64'h0, itar_pkg::SIZE_16, 1'b0, itar_pkg::RADIX_DEC, "0"},
            '{64'h0, itar_pkg::SIZE_64, 1'b1, RADIX_HEX, "0"},
            '{64'hffff, itar_pkg::SIZE_16, 1'b0, itar_pkg::RADIX_DEC, "65535"},
            '{64'hffff, itar_pkg::SIZE_16, 1'b1, itar_pkg::RADIX_DEC, "-1"},
            '{64'h8000, itar_pkg::SIZE_16, 1'b1, itar_pkg::RADIX_DEC, "-32768"},
            '{64'h7fff, itar_pkg::SIZE_16, 1'b1, itar_pkg::RADIX_DEC, "32767"},
            '{64'h8000_0000, itar_pkg::SIZE_32, 1'b1, itar_pkg::RADIX_DEC,
              "-2147483648"},
            '{64'hffff_ffff, itar_pkg::SIZE_32, 1'b0, itar_pkg::RADIX_DEC,
              "4294967295"},
            '{64'h8000_0000_0000_0000, itar_pkg::SIZE_64, 1'b1, itar_pkg::RADIX_DEC,
              "-9223372036854775808"},
            '{64'hffff_ffff_ffff_ffff, itar_pkg::SIZE_64, 1'b0, itar_pkg::RADIX_DEC,
              "18446744073709551615"},
            '{64'hffff_ffff_ffff_ffff, itar_pkg::SIZE_64, 1'b0, itar_pkg::RADIX_OCT,
              "1777777777777777777777"},
            // longest output: sign plus 22 octal digits
            '{64'h8000_0000_0000_0000, itar_pkg::SIZE_64, 1'b1, itar_pkg::RADIX_OCT,
              "-1000000000000000000000"},
            '{64'hffff_ffff_ffff_ffff, itar_pkg::SIZE_64, 1'b0, RADIX_HEX,
              "ffffffffffffffff"},
            '{64'h8000_0000_0000_0000, itar_pkg::SIZE_64, 1'b1, RADIX_HEX,
              "-8000000000000000"},
            '{64'hffff, itar_pkg::SIZE_16, 1'b0, itar_pkg::RADIX_OCT, "177777"},
            '{64'h8000, itar_pkg::SIZE_16, 1'b1, RADIX_HEX, "-8000"},
            // bits above the operand size are ignored
            '{64'hdead_beef_0000_002a, itar_pkg::SIZE_16, 1'b0, itar_pkg::RADIX_DEC,
              "42"},
            '{64'hffff_ffff_ffff_ffff, SIZE_ALT, 1'b1, itar_pkg::RADIX_DEC, "-1"},
            '{64'h00ff, itar_pkg::SIZE_16, 1'b0, RADIX_ALT, "ff"},
            '{64'h0123_4567_89ab_cdef, itar_pkg::SIZE_64, 1'b0, RADIX_HEX,
              "123456789abcdef"},
            '{64'hffff_fff6, itar_pkg::SIZE_32, 1'b1, itar_pkg::RADIX_DEC, "-10"},
            '{64'h7, itar_pkg::SIZE_16, 1'b0, itar_pkg::RADIX_OCT, "7"},
            '{64'h8, itar_pkg::SIZE_16, 1'b0, itar_pkg::RADIX_OCT, "10"},
            '{64'hfedc_ba98_7654_3210, itar_pkg::SIZE_64, 1'b1, itar_pkg::RADIX_DEC,
              ""},
            '{64'h5555_aaaa_1234_5678, itar_pkg::SIZE_32, 1'b1, itar_pkg::RADIX_OCT,
              ""}
        };

        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        foreach (directed_rows[r])
            offer_request(directed_rows[r].value, directed_rows[r].size,
                          directed_rows[r].is_signed, directed_rows[r].radix,
                          directed_rows[r].golden, 1'b0);

        for (int n = 0; n < N_RANDOM; n++) begin
            size      = 2'($urandom_range(0, 3));
            is_signed = 1'($urandom_range(0, 1));
            radix     = 2'($urandom_range(0, 3));
            op_width  = (size == itar_pkg::SIZE_16) ? 16 :
                        (size == itar_pkg::SIZE_32) ? 32 : 64;
            shape     = $urandom_range(0, 9);
            case (shape)
                0, 1: value = 64'($urandom_range(0, 40));
                2: begin
                    // most negative value, with junk above the operand size
                    value = 64'h1 << (op_width - 1);
                    if (op_width < 64)
                        value |= {$urandom, $urandom} << op_width;
                end
                3: value = '1;
                4: value = (64'h1 << (op_width - 1)) - 64'h1;
                5: value = (64'h1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
                default: value = {$urandom, $urandom};
            endcase
            // a run of back-to-back requests in the middle
            offer_request(value, size, is_signed, radix, "", n >= 300 && n < 370);
        end
        req_bus.valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("integer_to_ascii_radix_core_test: done, clean");
        else
            $display("integer_to_ascii_radix_core_test: done, errors");
        $finish;
    end

    // compare one received character against the oldest one owed
    task automatic check_character(input logic [6:0] got_char, input logic got_last);
        t_char_result owed;
        if (pending_chars.size() == 0) begin
            $display("%0t: character with none owed, expected none actual %h/%b",
                     $time, got_char, got_last);
            error_count++;
        end else begin
            owed = pending_chars.pop_front();
            if (got_char !== owed.ascii_char) begin
                $display("%0t: ascii_char mismatch, expected %h actual %h",
                         $time, owed.ascii_char, got_char);
                error_count++;
            end
            if (got_last !== owed.last_char) begin
                $display("%0t: last_char mismatch, expected %b actual %b",
                         $time, owed.last_char, got_last);
                error_count++;
            end
        end
    endtask

    // result side: checks at each edge, then decides ready for the next cycle
    initial begin
        int chars_seen;
        int hold_left;
        bit hold_done;

        chars_seen = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        rsp_bus.ready <= 1'b0;

        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
                check_character(rsp_bus.ascii_char, rsp_bus.last_char);
                chars_seen++;
            end

            // one long hold-off so the core backs up and stalls its requests
            if (!hold_done && chars_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (chars_seen >= 3000 && chars_seen < 4200) begin
                rsp_bus.ready <= 1'b1;
            end else begin
                rsp_bus.ready <= ($urandom_range(0, 99) >= 19);
            end
        end
    end

    // run limit, far beyond the slowest clean run
    initial begin
        #5_000_000;
        $display("integer_to_ascii_radix_core_test: done, errors");
        $finish;
    end

endmodule
